### design/opc_pkg.sv
// ----------------------------------------------------------------------------
// opc_pkg
// Shared types and constants for the obstacle proximity cost block.
// ----------------------------------------------------------------------------
package opc_pkg;

  // Default table depth
  localparam int unsigned OPC_MAX_OBSTACLES = 16;

  // Operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_COUNT     = 2'd0;
  localparam logic [1:0] CFG_COLLISION = 2'd1;
  localparam logic [1:0] CFG_NEIGHBOUR = 2'd2;

  // Band width beyond the radius, 0.5 m in 1/512 m
  localparam logic [16:0] BAND_UNITS = 17'd256;

  // Square root iterations: band q stays below 2^34
  localparam logic [4:0] SQ_ITER = 5'd17;

  // Shared multiplier operand selects
  localparam logic [2:0] MUL_SS = 3'd0;
  localparam logic [2:0] MUL_LL = 3'd1;
  localparam logic [2:0] MUL_WW = 3'd2;
  localparam logic [2:0] MUL_BB = 3'd3;
  localparam logic [2:0] MUL_MN = 3'd4;

  // Controller to datapath commands
  typedef struct packed {
    logic       load;
    logic       query;
    logic       diff_en;
    logic       mul_en;
    logic [2:0] mul_sel;
    logic       q_en;
    logic       sq_init;
    logic       sq_step;
    logic       m_en;
    logic       acc_add;
  } opc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic gate;
    logic in_radius;
    logic band;
  } opc_status_t;

endpackage

### design/opc_ram.sv
// ----------------------------------------------------------------------------
// opc_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module opc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### design/opc_ctrl.sv
// ----------------------------------------------------------------------------
// opc_ctrl
// Sequencer: walks the table entry by entry and steps the shared datapath.
// ----------------------------------------------------------------------------
module opc_ctrl import opc_pkg::*; #(
  parameter int unsigned MAX_OBSTACLES = OPC_MAX_OBSTACLES,
  localparam int unsigned IDX_W = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1,
  localparam int unsigned CNT_W = $clog2(MAX_OBSTACLES + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             operation_i,
  input  logic [4:0]       obstacle_count_i,
  input  opc_status_t      status_i,
  output opc_cmd_t         cmd_o,
  output logic [IDX_W-1:0] entry_sel_o,
  output logic             busy_o,
  output logic             done_o
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_RD    = 4'd1;
  localparam logic [3:0] ST_DIFF  = 4'd2;
  localparam logic [3:0] ST_GATE  = 4'd3;
  localparam logic [3:0] ST_MULL  = 4'd4;
  localparam logic [3:0] ST_MULW  = 4'd5;
  localparam logic [3:0] ST_MULB  = 4'd6;
  localparam logic [3:0] ST_QSUM  = 4'd7;
  localparam logic [3:0] ST_CLASS = 4'd8;
  localparam logic [3:0] ST_SQRT  = 4'd9;
  localparam logic [3:0] ST_MSUB  = 4'd10;
  localparam logic [3:0] ST_MARG  = 4'd11;
  localparam logic [3:0] ST_ACC   = 4'd12;
  localparam logic [3:0] ST_DONE  = 4'd13;

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] num_q, num_d;
  logic [4:0]       sq_cnt_q, sq_cnt_d;
  logic             accept;
  logic [3:0]       adv_state;
  logic [CNT_W-1:0] adv_idx;

  assign accept      = start_i && !busy_o;
  assign busy_o      = (state_q != ST_IDLE);
  assign done_o      = (state_q == ST_DONE);
  assign entry_sel_o = IDX_W'(idx_q);

  // Move to the next entry or finish
  always_comb begin
    if (CNT_W'(idx_q + 1'b1) == num_q) begin
      adv_state = ST_DONE;
      adv_idx   = idx_q;
    end else begin
      adv_state = ST_RD;
      adv_idx   = CNT_W'(idx_q + 1'b1);
    end
  end

  // Next state and commands
  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    num_d    = num_q;
    sq_cnt_d = sq_cnt_q;
    cmd_o    = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept && operation_i == OP_LOAD) begin
          cmd_o.load = 1'b1;
        end else if (accept) begin
          cmd_o.query = 1'b1;
          idx_d       = '0;
          if (32'(obstacle_count_i) > 32'(MAX_OBSTACLES)) begin
            num_d = CNT_W'(MAX_OBSTACLES);
          end else begin
            num_d = CNT_W'(obstacle_count_i);
          end
          state_d = (obstacle_count_i == 5'd0) ? ST_DONE : ST_RD;
        end
      end
      ST_RD: state_d = ST_DIFF;
      ST_DIFF: begin
        cmd_o.diff_en = 1'b1;
        state_d       = ST_GATE;
      end
      ST_GATE: begin
        if (status_i.gate) begin
          cmd_o.mul_en  = 1'b1;
          cmd_o.mul_sel = MUL_SS;
          state_d       = ST_MULL;
        end else begin
          state_d = adv_state;
          idx_d   = adv_idx;
        end
      end
      ST_MULL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_LL;
        state_d       = ST_MULW;
      end
      ST_MULW: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_WW;
        state_d       = ST_MULB;
      end
      ST_MULB: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_BB;
        state_d       = ST_QSUM;
      end
      ST_QSUM: begin
        cmd_o.q_en = 1'b1;
        state_d    = ST_CLASS;
      end
      ST_CLASS: begin
        if (status_i.in_radius) begin
          state_d = ST_ACC;
        end else if (status_i.band) begin
          cmd_o.sq_init = 1'b1;
          sq_cnt_d      = '0;
          state_d       = ST_SQRT;
        end else begin
          state_d = adv_state;
          idx_d   = adv_idx;
        end
      end
      ST_SQRT: begin
        cmd_o.sq_step = 1'b1;
        sq_cnt_d      = sq_cnt_q + 5'd1;
        if (sq_cnt_q == SQ_ITER - 5'd1) begin
          state_d = ST_MSUB;
        end
      end
      ST_MSUB: begin
        cmd_o.m_en = 1'b1;
        state_d    = ST_MARG;
      end
      ST_MARG: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_MN;
        state_d       = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc_add = 1'b1;
        state_d       = adv_state;
        idx_d         = adv_idx;
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      num_q    <= '0;
      sq_cnt_q <= '0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      num_q    <= num_d;
      sq_cnt_q <= sq_cnt_d;
    end
  end

  // A result word lasts one cycle
  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done strobe longer than one cycle");

  // A query start makes the block busy
  a_query_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && operation_i == OP_QUERY) |=> busy_o) else $error("query not started");

  // Loads never produce a result
  a_load_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && operation_i == OP_LOAD) |=> !busy_o && !done_o)
    else $error("load produced activity");

  // The scan index stays inside the scanned range
  a_idx_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_o && !done_o) |-> (idx_q < num_q)) else $error("scan index out of range");

endmodule

### design/opc_dp.sv
// ----------------------------------------------------------------------------
// opc_dp
// Datapath: entry table, shared multiplier, bit-serial square root, summing.
// ----------------------------------------------------------------------------
module opc_dp import opc_pkg::*; #(
  parameter int unsigned MAX_OBSTACLES = OPC_MAX_OBSTACLES,
  localparam int unsigned IDX_W = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  opc_cmd_t           cmd_i,
  input  logic [IDX_W-1:0]   entry_sel_i,
  input  logic [3:0]         entry_index_i,
  input  logic signed [23:0] obstacle_s_i,
  input  logic signed [23:0] obstacle_l_i,
  input  logic [15:0]        obstacle_width_i,
  input  logic [15:0]        obstacle_length_i,
  input  logic               obstacle_valid_i,
  input  logic signed [23:0] point_s_i,
  input  logic signed [23:0] point_l_i,
  input  logic [15:0]        collision_cost_i,
  input  logic [15:0]        neighbour_cost_i,
  output opc_status_t        status_o,
  output logic [39:0]        total_cost_o
);

  logic [MAX_OBSTACLES-1:0] valid_q;
  logic                     wr_ok;
  logic [79:0]              rd_data;
  logic [23:0]              rd_s, rd_l;
  logic [15:0]              rd_w, rd_len;

  logic [23:0] ps_q, pl_q;
  logic [24:0] ds, dl, ads, adl;
  logic [15:0] ads_q;
  logic [24:0] adl_q;
  logic [15:0] w_q;
  logic [16:0] wb_q;
  logic        gate_q;

  logic [24:0] mul_a, mul_b;
  logic [49:0] mul_p;
  logic [31:0] sq_s_q, w2_q;
  logic [49:0] sq_l_q;
  logic [33:0] wb2_q;
  logic [23:0] prod_q;
  logic [52:0] q_q;

  logic [33:0] sq_src_q;
  logic [19:0] rem_q;
  logic [16:0] root_q;
  logic [21:0] rem_sh, trial;
  logic [8:0]  m_q;

  logic [39:0] acc_q;
  logic [23:0] add_val;
  logic [40:0] acc_sum;

  // Entry table: fields in RAM, valid marks in flops
  assign wr_ok = cmd_i.load && (32'(entry_index_i) < 32'(MAX_OBSTACLES));

  opc_ram #(
    .WIDTH (80),
    .DEPTH (MAX_OBSTACLES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_ok),
    .waddr_i (IDX_W'(entry_index_i)),
    .wdata_i ({obstacle_s_i, obstacle_l_i, obstacle_width_i, obstacle_length_i}),
    .raddr_i (entry_sel_i),
    .rdata_o (rd_data)
  );

  assign {rd_s, rd_l, rd_w, rd_len} = rd_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_ok) begin
      valid_q[IDX_W'(entry_index_i)] <= obstacle_valid_i;
    end
  end

  // Point capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.query) begin
      ps_q <= point_s_i;
      pl_q <= point_l_i;
    end
  end

  // Absolute differences and longitudinal gate
  assign ds  = {rd_s[23], rd_s} - {ps_q[23], ps_q};
  assign dl  = {rd_l[23], rd_l} - {pl_q[23], pl_q};
  assign ads = ds[24] ? (25'd0 - ds) : ds;
  assign adl = dl[24] ? (25'd0 - dl) : dl;

  always_ff @(posedge clk_i) begin
    if (cmd_i.diff_en) begin
      ads_q  <= ads[15:0];
      adl_q  <= adl;
      w_q    <= rd_w;
      wb_q   <= {1'b0, rd_w} + BAND_UNITS;
      gate_q <= valid_q[entry_sel_i] && (ads <= {9'd0, rd_len});
    end
  end

  // Shared multiplier
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_SS: begin
        mul_a = {9'd0, ads_q};
        mul_b = {9'd0, ads_q};
      end
      MUL_LL: begin
        mul_a = adl_q;
        mul_b = adl_q;
      end
      MUL_WW: begin
        mul_a = {9'd0, w_q};
        mul_b = {9'd0, w_q};
      end
      MUL_BB: begin
        mul_a = {8'd0, wb_q};
        mul_b = {8'd0, wb_q};
      end
      MUL_MN: begin
        mul_a = {16'd0, m_q};
        mul_b = {9'd0, neighbour_cost_i};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      case (cmd_i.mul_sel)
        MUL_SS:  sq_s_q <= mul_p[31:0];
        MUL_LL:  sq_l_q <= mul_p;
        MUL_WW:  w2_q   <= mul_p[31:0];
        MUL_BB:  wb2_q  <= mul_p[33:0];
        MUL_MN:  prod_q <= mul_p[23:0];
        default: prod_q <= prod_q;
      endcase
    end
  end

  // Squared distance in 1/512 m units
  always_ff @(posedge clk_i) begin
    if (cmd_i.q_en) begin
      q_q <= {(51'(sq_l_q) + 51'(sq_s_q)), 2'b00};
    end
  end

  assign status_o.gate      = gate_q;
  assign status_o.in_radius = (q_q <= 53'(w2_q));
  assign status_o.band      = (q_q < 53'(wb2_q));

  // Bit-serial square root, two radicand bits per step
  assign rem_sh = {rem_q, sq_src_q[33:32]};
  assign trial  = {3'd0, root_q, 2'b01};

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_init) begin
      sq_src_q <= q_q[33:0];
      rem_q    <= '0;
      root_q   <= '0;
    end else if (cmd_i.sq_step) begin
      sq_src_q <= {sq_src_q[31:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= 20'(rem_sh - trial);
        root_q <= {root_q[15:0], 1'b1};
      end else begin
        rem_q  <= rem_sh[19:0];
        root_q <= {root_q[15:0], 1'b0};
      end
    end
  end

  // Margin inside the band, 1..256
  always_ff @(posedge clk_i) begin
    if (cmd_i.m_en) begin
      m_q <= 9'(wb_q - root_q);
    end
  end

  // Saturating sum
  assign add_val = status_o.in_radius ? {collision_cost_i, 8'd0} : prod_q;
  assign acc_sum = {1'b0, acc_q} + 41'(add_val);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (cmd_i.query) begin
      acc_q <= '0;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_sum[40] ? '1 : acc_sum[39:0];
    end
  end

  assign total_cost_o = acc_q;

  // Band margin is never zero when it feeds the multiplier
  a_margin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mul_en && cmd_i.mul_sel == MUL_MN |-> (m_q != 9'd0))
    else $error("band margin zero");

  // Sum never falls during a query
  a_acc_mono : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.acc_add) |-> (acc_q >= $past(acc_q))) else $error("sum decreased");

  // Root stays below band edge after the last step
  a_root : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.m_en |-> (root_q < wb_q)) else $error("root outside band");

endmodule

### design/obstacle_proximity_cost.sv
// ----------------------------------------------------------------------------
// obstacle_proximity_cost
// Obstacle table with a summed proximity cost query at a road point.
// ----------------------------------------------------------------------------
// A load word (operation 0) writes one table slot and gives no result. A
// query word (operation 1) scans slots 0..count-1, with count capped at the
// table depth, and pulses done_o for one cycle with total_cost_o; the
// receiver cannot stall, so the result must be taken in that cycle. busy
// is high from the cycle after a query start until the done cycle. An
// entry that passes the gate is squared on the one shared 25x25 multiplier
// (four squares per entry); inside the radius it adds the collision cost,
// in the band the 17-step bit-serial square root gives a margin that scales
// the neighbour cost. The configuration port is always ready.
// ----------------------------------------------------------------------------
module obstacle_proximity_cost import opc_pkg::*; #(
  parameter int unsigned MAX_OBSTACLES = OPC_MAX_OBSTACLES,
  localparam int unsigned IDX_W = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  output logic               done_o,
  input  logic               operation_i,
  input  logic [3:0]         entry_index_i,
  input  logic signed [23:0] obstacle_s_i,
  input  logic signed [23:0] obstacle_l_i,
  input  logic [15:0]        obstacle_width_i,
  input  logic [15:0]        obstacle_length_i,
  input  logic               obstacle_valid_i,
  input  logic signed [23:0] point_s_i,
  input  logic signed [23:0] point_l_i,
  output logic [39:0]        total_cost_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  logic [4:0]       count_q;
  logic [15:0]      coll_q, neib_q;
  opc_cmd_t         cmd;
  opc_status_t      status;
  logic [IDX_W-1:0] entry_sel;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      coll_q  <= '0;
      neib_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_COUNT:     count_q <= cfg_data_i[4:0];
        CFG_COLLISION: coll_q  <= cfg_data_i;
        CFG_NEIGHBOUR: neib_q  <= cfg_data_i;
        default:       count_q <= count_q;
      endcase
    end
  end

  opc_ctrl #(
    .MAX_OBSTACLES (MAX_OBSTACLES)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .operation_i      (operation_i),
    .obstacle_count_i (count_q),
    .status_i         (status),
    .cmd_o            (cmd),
    .entry_sel_o      (entry_sel),
    .busy_o           (busy),
    .done_o           (done_o)
  );

  opc_dp #(
    .MAX_OBSTACLES (MAX_OBSTACLES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .entry_sel_i       (entry_sel),
    .entry_index_i     (entry_index_i),
    .obstacle_s_i      (obstacle_s_i),
    .obstacle_l_i      (obstacle_l_i),
    .obstacle_width_i  (obstacle_width_i),
    .obstacle_length_i (obstacle_length_i),
    .obstacle_valid_i  (obstacle_valid_i),
    .point_s_i         (point_s_i),
    .point_l_i         (point_l_i),
    .collision_cost_i  (coll_q),
    .neighbour_cost_i  (neib_q),
    .status_o          (status),
    .total_cost_o      (total_cost_o)
  );

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the obstacle proximity cost block: loads obstacle
// table words and queries road points, predicts every summed cost in the
// bench and compares each done_o word against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import opc_pkg::*;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned SLOTS = OPC_MAX_OBSTACLES;
  localparam logic [39:0] COST_CEIL = 40'hFF_FFFF_FFFF;
  localparam int unsigned STALL_LIMIT = 5000;

  typedef struct {
    logic               op;
    logic [3:0]         idx;
    logic signed [23:0] os;
    logic signed [23:0] ol;
    logic [15:0]        ow;
    logic [15:0]        olen;
    logic               ov;
    logic signed [23:0] ps;
    logic signed [23:0] pl;
    bit                 chk;
    logic [39:0]        want;
  } stim_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               done_o;
  logic               operation_i = OP_LOAD;
  logic [3:0]         entry_index_i = '0;
  logic signed [23:0] obstacle_s_i = '0;
  logic signed [23:0] obstacle_l_i = '0;
  logic [15:0]        obstacle_width_i = '0;
  logic [15:0]        obstacle_length_i = '0;
  logic               obstacle_valid_i = 1'b0;
  logic signed [23:0] point_s_i = '0;
  logic signed [23:0] point_l_i = '0;
  logic [39:0]        total_cost_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = CFG_COUNT;
  logic [15:0]        cfg_data_i = '0;

  // Bench copy of the obstacle table and registers
  logic signed [23:0] tbl_s [SLOTS];
  logic signed [23:0] tbl_l [SLOTS];
  logic [15:0]        tbl_w [SLOTS];
  logic [15:0]        tbl_len [SLOTS];
  logic               tbl_ok [SLOTS];
  logic [4:0]         scan_count = '0;
  logic [15:0]        hit_cost = '0;
  logic [15:0]        ramp_cost = '0;

  logic [39:0] cost_q[$];
  int unsigned errors = 0;
  int unsigned loads_done = 0;
  int unsigned queries_done = 0;
  int unsigned stall_cycles = 0;
  bit          idle_on = 1'b1;

  obstacle_proximity_cost dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    errors++;
  endtask

  // Floor square root, one result bit at a time
  function automatic logic [63:0] floor_root(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  // Summed cost of the scanned entries at one road point
  function automatic logic [39:0] point_cost(input logic signed [23:0] ps,
                                              input logic signed [23:0] pl);
    logic [63:0] sum, ads, adl, w, q, add;
    longint ds, dl;
    int n;
    sum = '0;
    n = (scan_count > SLOTS) ? SLOTS : scan_count;
    for (int i = 0; i < n; i++) begin
      if (!tbl_ok[i]) continue;
      ds = longint'(tbl_s[i]) - longint'(ps);
      dl = longint'(tbl_l[i]) - longint'(pl);
      ads = (ds < 0) ? -ds : ds;
      adl = (dl < 0) ? -dl : dl;
      if (ads > tbl_len[i]) continue;
      w = tbl_w[i];
      q = 4 * (ads * ads + adl * adl);
      add = '0;
      if (q <= w * w) add = 64'(hit_cost) * 256;
      else if (q < (w + 256) * (w + 256)) add = (w + 256 - floor_root(q)) * ramp_cost;
      sum += add;
      if (sum > COST_CEIL) sum = COST_CEIL;
    end
    return sum[39:0];
  endfunction

  // Applies an accepted word to the bench table; queries queue a cost
  task automatic predict_word(input stim_t it);
    logic [39:0] c;
    if (it.op == OP_LOAD) begin
      tbl_s[it.idx] = it.os;
      tbl_l[it.idx] = it.ol;
      tbl_w[it.idx] = it.ow;
      tbl_len[it.idx] = it.olen;
      tbl_ok[it.idx] = it.ov;
      loads_done++;
    end else begin
      c = point_cost(it.ps, it.pl);
      if (it.chk && c !== it.want)
        report_mismatch($sformatf("table cost %0d, bench predicts %0d", it.want, c));
      cost_q = {cost_q, (it.chk ? it.want : c)};
      queries_done++;
    end
  endtask

  // Drives one word and holds it until the block takes it
  task automatic send_word(input stim_t it);
    start <= 1'b1;
    operation_i <= it.op;
    entry_index_i <= it.idx;
    obstacle_s_i <= it.os;
    obstacle_l_i <= it.ol;
    obstacle_width_i <= it.ow;
    obstacle_length_i <= it.olen;
    obstacle_valid_i <= it.ov;
    point_s_i <= it.ps;
    point_l_i <= it.pl;
    do @(posedge clk_i); while (busy);
    stall_cycles = 0;
    predict_word(it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // One register write, after which the channel goes idle
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    stall_cycles = 0;
    case (idx)
      CFG_COUNT:     scan_count = data[4:0];
      CFG_COLLISION: hit_cost = data;
      CFG_NEIGHBOUR: ramp_cost = data;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Lets every queued cost drain, then covers a trailing load word
  task automatic drain;
    start <= 1'b0;
    while (cost_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic stim_t mk(input logic op, input logic [3:0] idx,
                               input int os, input int ol, input int ow, input int olen,
                               input logic ov, input int ps, input int pl,
                               input bit chk, input logic [39:0] want);
    stim_t it;
    it = '{op, idx, os[23:0], ol[23:0], ow[15:0], olen[15:0], ov, ps[23:0], pl[23:0],
           chk, want};
    return it;
  endfunction

  function automatic logic [23:0] near(input logic [23:0] base);
    if ($urandom_range(0, 9) == 0) return 24'($urandom);
    return base + 24'($urandom_range(0, 4000)) - 24'd2000;
  endfunction

  function automatic stim_t rand_word(input logic [23:0] bs, input logic [23:0] bl);
    stim_t it;
    it.op = ($urandom_range(0, 99) < 45) ? OP_QUERY : OP_LOAD;
    it.idx = 4'($urandom);
    it.os = near(bs);
    it.ol = near(bl);
    it.ow = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1500));
    it.olen = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'hFFFF;
    it.ov = ($urandom_range(0, 9) != 0);
    it.ps = near(bs);
    it.pl = near(bl);
    it.chk = 1'b0;
    it.want = '0;
    return it;
  endfunction

  // Result checker: done_o can not be held off
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      stall_cycles = 0;
      if (cost_q.size() == 0)
        report_mismatch($sformatf("unexpected cost word %0d", total_cost_o));
      else if (total_cost_o !== cost_q[0])
        report_mismatch($sformatf("total_cost %0d, expected %0d", total_cost_o,
                                  cost_q.pop_front()));
      else
        void'(cost_q.pop_front());
    end
  end

  // Watchdog on cycles with no traffic
  always @(posedge clk_i) begin
    stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout after %0d quiet cycles", STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    stim_t dir_rows[$];
    logic [4:0] counts[6];
    logic [23:0] bs, bl;
    for (int i = 0; i < SLOTS; i++) tbl_ok[i] = 1'b0;

    // Directed rows; row 0 runs on reset registers
    dir_rows = {dir_rows, mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 1, 40'd0)};
    dir_rows = {dir_rows, mk(OP_LOAD, 0, 0, 0, 512, 65535, 1, 0, 0, 0, 0)};
    dir_rows = {dir_rows, mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 1, 40'd25600)};
    dir_rows = {dir_rows, mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 300, 0, 0)};
    dir_rows = {dir_rows, mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 384, 1, 40'd0)};
    dir_rows = {dir_rows, mk(OP_LOAD, 1, 8388607, -8388608, 65535, 65535, 1, 0, 0, 0, 0)};
    dir_rows = {dir_rows, mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 8388607, -8388608, 1, 40'd25600)};
    dir_rows = {dir_rows, mk(OP_QUERY, 0, 0, 0, 0, 0, 0, -8388608, 8388607, 1, 40'd0)};
    dir_rows = {dir_rows, mk(OP_LOAD, 2, 0, 0, 0, 0, 1, -1, -1, 0, 0)};
    dir_rows = {dir_rows, mk(OP_QUERY, 15, -1, -1, 65535, 65535, 1, 0, 0, 1, 40'd51200)};
    dir_rows = {dir_rows, mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0)};
    dir_rows = {dir_rows, mk(OP_LOAD, 3, 0, 0, 512, 100, 0, 0, 0, 0, 0)};
    dir_rows = {dir_rows, mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 1, 40'd51200)};
    dir_rows = {dir_rows, mk(OP_LOAD, 0, 0, 0, 512, 65535, 0, 0, 0, 0, 0)};
    dir_rows = {dir_rows, mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 1, 40'd25600)};
    dir_rows = {dir_rows, mk(OP_LOAD, 15, -8388608, 8388607, 0, 0, 1, 0, 0, 0, 0)};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (i == 1) begin
        drain();
        write_reg(CFG_COUNT, 16'd4);
        write_reg(CFG_COLLISION, 16'd100);
        write_reg(CFG_NEIGHBOUR, 16'd10);
      end
      send_word(dir_rows[i]);
    end

    // Random phases, each with its own register setting and obstacle cluster
    counts = '{5'd0, 5'd1, 5'd16, 5'd17, 5'd31, 5'd8};
    for (int p = 0; p < 10; p++) begin
      drain();
      idle_on = (p < 9);
      write_reg(CFG_COUNT, (p < 6) ? {11'd0, counts[p]} : 16'($urandom_range(0, 31)));
      write_reg(CFG_COLLISION, (p == 2) ? 16'hFFFF : (p == 3) ? 16'd0 : 16'($urandom));
      write_reg(CFG_NEIGHBOUR, (p == 2) ? 16'hFFFF : (p == 4) ? 16'd0 : 16'($urandom));
      write_reg(CFG_UNUSED, 16'($urandom));
      bs = ($urandom_range(0, 1) == 0) ? 24'($urandom) : 24'($urandom_range(0, 8000));
      bl = 24'($urandom);
      for (int k = 0; k < 175; k++) send_word(rand_word(bs, bl));
    end

    start <= 1'b0;
    while (cost_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("Covered %0d table loads and %0d cost queries over 11 register settings",
             loads_done, queries_done);
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
